// ----- rtl/core/lmb_pkg.sv -----
// Shared widths, register codes, colour type and constants of the bifurcation plotter.
package lmb_pkg;

  localparam int unsigned PixW   = 12;  // column and row fields
  localparam int unsigned CfgW   = 13;  // widest configuration register
  localparam int unsigned CntCfgW = 8;  // iteration count register
  localparam int unsigned AddrW  = 2;   // configuration register index
  localparam int unsigned ColW   = 8;   // one colour channel

  typedef enum logic [AddrW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COUNT  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } rgb_t;

  localparam logic [ColW-1:0] HueLow  = 8'd129;
  localparam logic [ColW-1:0] HueHigh = 8'd255;
  localparam logic [ColW-1:0] RedRst  = 8'd255;
  localparam logic [ColW-1:0] GrnRst  = 8'd129;
  localparam logic [ColW-1:0] BluRst  = 8'd130;

  localparam logic [CfgW-1:0]    WidthRst  = 13'd1024;
  localparam logic [CfgW-1:0]    HeightRst = 13'd1024;
  localparam logic [CntCfgW-1:0] CountRst  = 8'd128;

endpackage

// ----- rtl/core/lmb_mul.sv -----
// Shared multiplier with registered product.
module lmb_mul #(
  parameter int unsigned Width = 32
) (
  input  logic               clk_i,
  input  logic [Width-1:0]   a_i,
  input  logic [Width-1:0]   b_i,
  output logic [2*Width-1:0] prod_o
);

  logic [2*Width-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/core/lmb_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating when the quotient overflows.
module lmb_div #(
  parameter int unsigned QuotW = 32,
  parameter int unsigned DivW  = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(QuotW);

  logic             busy_q, sat_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DivW-1:0]  rem_q, divisor_q;
  logic [QuotW-1:0] quot_q;
  logic [DivW:0]    rem2;
  logic             ge;
  logic [DivW:0]    rem_next;

  assign rem2     = {rem_q, 1'b0};
  assign ge       = rem2 >= {1'b0, divisor_q};
  assign rem_next = ge ? (rem2 - {1'b0, divisor_q}) : rem2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        sat_q  <= dividend_i >= divisor_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (sat_q || cnt_q == CntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Payload: remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      if (sat_q) begin
        quot_q <= '1;
      end else begin
        rem_q  <= rem_next[DivW-1:0];
        quot_q <= {quot_q[QuotW-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/core/lmb_hue.sv -----
// Six-phase rainbow colour machine, one step per column.
module lmb_hue import lmb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  output rgb_t colour_o
);

  typedef enum logic [2:0] {
    PH_BLUE_UP    = 3'd0,
    PH_RED_DOWN   = 3'd1,
    PH_GREEN_UP   = 3'd2,
    PH_BLUE_DOWN  = 3'd3,
    PH_RED_UP     = 3'd4,
    PH_GREEN_DOWN = 3'd5
  } hue_phase_e;

  hue_phase_e      phase_q, phase_d;
  logic [ColW-1:0] r_q, g_q, b_q;
  logic [ColW-1:0] r_d, g_d, b_d;
  logic            corner;

  assign corner = (r_q == HueHigh && g_q == b_q) || (r_q == b_q && g_q == HueLow) ||
                  (r_q == g_q && b_q == HueHigh) || (r_q == HueLow && g_q == b_q) ||
                  (r_q == b_q && g_q == HueHigh) || (r_q == g_q && b_q == HueLow);

  always_comb begin
    phase_d = phase_q;
    if (corner) begin
      case (phase_q)
        PH_BLUE_UP:   phase_d = PH_RED_DOWN;
        PH_RED_DOWN:  phase_d = PH_GREEN_UP;
        PH_GREEN_UP:  phase_d = PH_BLUE_DOWN;
        PH_BLUE_DOWN: phase_d = PH_RED_UP;
        PH_RED_UP:    phase_d = PH_GREEN_DOWN;
        default:      phase_d = PH_BLUE_UP;
      endcase
    end
    r_d = r_q;
    g_d = g_q;
    b_d = b_q;
    case (phase_d)
      PH_BLUE_UP:   b_d = b_q + 1'b1;
      PH_RED_DOWN:  r_d = r_q - 1'b1;
      PH_GREEN_UP:  g_d = g_q + 1'b1;
      PH_BLUE_DOWN: b_d = b_q - 1'b1;
      PH_RED_UP:    r_d = r_q + 1'b1;
      default:      g_d = g_q - 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BLUE_UP;
      r_q     <= RedRst;
      g_q     <= GrnRst;
      b_q     <= BluRst;
    end else if (advance_i) begin
      phase_q <= phase_d;
      r_q     <= r_d;
      g_q     <= g_d;
      b_q     <= b_d;
    end
  end

  assign colour_o = '{red: r_q, green: g_q, blue: b_q};

endmodule

// ----- rtl/core/logistic_map_bifurcation_plotter.sv -----
// Top level of the logistic map bifurcation plotter: sequencer, orbit state and output word.
//
// One input word carries a column index. The block steps its rainbow colour, derives the
// growth rate k = 4*column/(width-1) in Q2.(F-1) with a one-bit-per-cycle divider (saturating
// just below 4 for columns at or past width-1), restarts the orbit at 0.785 and runs
// x = k*x*(1-x) for the configured count on a single shared registered multiplier. Each
// iteration forms x*(1-x), then k*p; iterations past half the count also form the row
// product height*x and may emit a pixel word. One point is held back so the final point of
// a column can carry last_point; rows at or beyond the height are dropped. The input is
// ready only between columns; the output word is registered, so a new column can be taken
// while the last word of the previous one still waits. Configuration writes take effect at
// once and must only happen while the block is idle.
module logistic_map_bifurcation_plotter import lmb_pkg::*; #(
  parameter int unsigned MAX_ITERATIONS = 128,
  parameter int unsigned FRACTION_BITS  = 31,
  parameter int unsigned MAX_SIDE       = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [AddrW-1:0]    cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // column input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     column_i,
  // pixel output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     pixel_x_o,
  output logic [PixW-1:0]     pixel_y_o,
  output logic [ColW-1:0]     red_o,
  output logic [ColW-1:0]     green_o,
  output logic [ColW-1:0]     blue_o,
  output logic                last_point_o
);

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned MW   = F + 1;             // multiplier operand width, also k width
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned CntW = $clog2(MAX_ITERATIONS + 1);
  localparam logic [63:0] X0Wide = ((64'd785 << FRACTION_BITS) + 64'd500) / 64'd1000;
  localparam logic [F-1:0] X0   = X0Wide[F-1:0];

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_P, S_Q, S_X, S_ROW, S_END
  } state_e;

  // configuration registers
  logic [CfgW-1:0]    width_q, height_q;
  logic [CntCfgW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      count_q  <= CountRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        REG_COUNT:  count_q  <= cfg_wdata_i[CntCfgW-1:0];
        default: ;
      endcase
    end
  end

  // clamp the registers into the supported range
  logic [CfgW-1:0] width_eff, height_eff, divisor;
  logic [CntW-1:0] count_eff;

  always_comb begin
    width_eff = width_q;
    if (width_q < CfgW'(2))        width_eff = CfgW'(2);
    if (width_q > CfgW'(MAX_SIDE)) width_eff = CfgW'(MAX_SIDE);
    height_eff = (height_q > CfgW'(MAX_SIDE)) ? CfgW'(MAX_SIDE) : height_q;
    count_eff  = (count_q > CntCfgW'(MAX_ITERATIONS)) ? CntW'(MAX_ITERATIONS)
                                                        : CntW'(count_q);
  end

  assign divisor = width_eff - 1'b1;

  state_e          state_q;
  logic            in_acc;
  logic [PixW-1:0] column_q;
  logic [MW-1:0]   k_q;
  logic [F-1:0]    x_q;
  logic [CntW-1:0] iter_q;
  logic            held_v_q;
  logic [PixW-1:0] held_row_q;
  logic            out_valid_q, last_q;
  logic [PixW-1:0] px_q, py_q;
  rgb_t            col_out_q;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;

  // colour machine
  rgb_t colour;

  lmb_hue u_hue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_acc),
    .colour_o  (colour)
  );

  // growth rate divider: k = column * 2^(F+1) / (width-1)
  logic          div_done;
  logic [MW-1:0] div_quot;

  lmb_div #(.QuotW(MW), .DivW(CfgW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (CfgW'(column_i)),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // shared multiplier and its operand select
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [MW-1:0] one_minus_x;
  logic [F-1:0]  p_val, x_new;
  logic [CfgW-1:0] row;

  lmb_mul #(.Width(MW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign one_minus_x = {1'b1, {F{1'b0}}} - {1'b0, x_q};
  assign p_val       = prod[2*F-1:F];
  // x = k*p >> (F-1), clamped below one
  assign x_new       = (prod[PW-1:2*F-1] != '0) ? {F{1'b1}} : prod[2*F-2:F-1];
  assign row         = prod[F+CfgW-1:F];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_P: begin
        mul_a = {1'b0, x_q};
        mul_b = one_minus_x;
      end
      S_Q: begin
        mul_a = k_q;
        mul_b = {1'b0, p_val};
      end
      S_X: begin
        mul_a = MW'(height_eff);
        mul_b = {1'b0, x_new};
      end
      S_ROW: begin
        // hold the row product while the output is stalled
        mul_a = MW'(height_eff);
        mul_b = {1'b0, x_q};
      end
      default: ;
    endcase
  end

  logic out_free, plot_iter, last_iter, row_hit, emit;

  assign out_free  = !out_valid_q || out_ready_i;
  assign plot_iter = iter_q > (count_eff >> 1);
  assign last_iter = (iter_q + CntW'(1)) == count_eff;
  assign row_hit   = row < height_eff;
  // a held point leaves for the output register this cycle
  assign emit      = held_v_q && out_free &&
                     ((state_q == S_ROW && row_hit) || state_q == S_END);

  // sequencer, orbit registers, held point and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      k_q         <= '0;
      x_q         <= '0;
      column_q    <= '0;
      held_row_q  <= '0;
      px_q        <= '0;
      py_q        <= '0;
      col_out_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            column_q <= column_i;
            held_v_q <= 1'b0;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            k_q    <= div_quot;
            x_q    <= X0;
            iter_q <= '0;
            state_q <= (count_eff == '0) ? S_IDLE : S_P;
          end
        end
        S_P: begin
          state_q <= S_Q;
        end
        S_Q: begin
          state_q <= S_X;
        end
        S_X: begin
          x_q <= x_new;
          if (plot_iter) begin
            state_q <= S_ROW;
          end else begin
            iter_q  <= iter_q + 1'b1;
            state_q <= last_iter ? S_END : S_P;
          end
        end
        S_ROW: begin
          if (!row_hit || !held_v_q || out_free) begin
            if (row_hit) begin
              // push the previously held point out, hold the new one
              if (held_v_q) begin
                out_valid_q <= 1'b1;
                px_q        <= column_q;
                py_q        <= held_row_q;
                col_out_q   <= colour;
                last_q      <= 1'b0;
              end
              held_v_q   <= 1'b1;
              held_row_q <= row[PixW-1:0];
            end
            iter_q  <= iter_q + 1'b1;
            state_q <= last_iter ? S_END : S_P;
          end
        end
        S_END: begin
          if (!held_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            px_q        <= column_q;
            py_q        <= held_row_q;
            col_out_q   <= colour;
            last_q      <= 1'b1;
            held_v_q    <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign red_o        = col_out_q.red;
  assign green_o      = col_out_q.green;
  assign blue_o       = col_out_q.blue;
  assign last_point_o = last_q;

endmodule

// ----- rtl/core/lmb_checker.sv -----
// Port-level checks of the bifurcation plotter and their binding to the top level.
module lmb_checker import lmb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [AddrW-1:0] cfg_addr_i,
  input logic [CfgW-1:0]  cfg_wdata_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [PixW-1:0]  column_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PixW-1:0]  pixel_x_o,
  input logic [PixW-1:0]  pixel_y_o,
  input logic [ColW-1:0]  red_o,
  input logic [ColW-1:0]  green_o,
  input logic [ColW-1:0]  blue_o,
  input logic             last_point_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(last_point_o))
    else $error("stalled output word changed");

  // a taken column blocks the input for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after taking a column");

  // a non-final word means the column is still in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_point_o |-> !in_ready_o)
    else $error("input ready while a column is unfinished");

endmodule

bind logistic_map_bifurcation_plotter lmb_checker u_lmb_checker (.*);
